/* design/tsr_pkg.sv */
// ----------------------------------------------------------------------------
// tsr_pkg : shared types and constants for the TCP segment reorder chain
// Payload structs, command codes, controller states and the datapath
// command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package tsr_pkg;

   localparam int PoolDepth = 64;
   localparam int IdxW      = $clog2(PoolDepth);
   localparam int CntW      = $clog2(PoolDepth + 1);

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_EMIT  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   localparam logic [0:0] REG_FALLBACK = 1'b0;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] seq_number;
      logic [15:0] tcp_length;
      logic [15:0] captured_length;
   } req_type;

   typedef struct packed {
      logic [5:0]  slot_index;
      logic [31:0] seg_seq;
      logic [15:0] byte_count;
      logic        fallback_used;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SORT_RD,    // read key of element i
      ST_SORT_STEP,  // fetch slot order[j-1] or place
      ST_SORT_PREV,  // read key of the fetched slot
      ST_SORT_CMP,   // compare, then shift or place
      ST_WALK_HEAD,  // load the highest element as chain start
      ST_WALK_RD,    // fetch slot order[i-1]
      ST_WALK_LOAD,  // read fields of the fetched slot
      ST_WALK_EVAL,  // decide keep / skip
      ST_DECIDE,
      ST_OUT_RD,     // fetch slot to emit
      ST_OUT_LOAD,   // read fields of the fetched slot
      ST_OUT_SEND    // hold result until taken
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic init_sort;    // i=0
      logic rd_key;       // latch key of slot i, j=i
      logic rd_prev;      // fetch slot order[j-1]
      logic ld_prev;      // read key of fetched slot
      logic shift;        // order[j]=order[j-1], j--
      logic place;        // order[j]=i, i++
      logic init_walk;    // start walk, fetch slot order[n-1]
      logic ld_head;      // chain start from fetched slot
      logic rd_walk;      // fetch slot order[i-1]
      logic ld_walk;      // read fields of fetched slot
      logic eval_walk;    // evaluate and advance walk
      logic init_out;
      logic rd_out;
      logic ld_out;
      logic adv_out;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic pool_empty;
      logic sort_done;    // i == n
      logic j_zero;
      logic less;         // key less than order[j-1]
      logic walk_done;    // i == 0
      logic out_done;     // set when the loaded item is the last
   } dp_sts_type;

endpackage

`default_nettype wire

/* design/tsr_ctrl.sv */
// ----------------------------------------------------------------------------
// tsr_ctrl : controller for the TCP segment reorder chain
// Sequences the insertion sort, the chain walk and the result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module tsr_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start_emit,
   input  tsr_pkg::dp_sts_type sts,
   input  wire                 rsp_take,
   output tsr_pkg::dp_cmd_type cmd,
   output logic                busy,
   output logic                rsp_valid
);
   import tsr_pkg::*;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_emit && !sts.pool_empty) state_in = ST_SORT_RD;
         end
         ST_SORT_RD: begin
            if (sts.sort_done) state_in = ST_WALK_HEAD;
            else state_in = ST_SORT_STEP;
         end
         ST_SORT_STEP: begin
            if (sts.j_zero) state_in = ST_SORT_RD;
            else state_in = ST_SORT_PREV;
         end
         ST_SORT_PREV: state_in = ST_SORT_CMP;
         ST_SORT_CMP: begin
            if (sts.less) state_in = ST_SORT_STEP;
            else state_in = ST_SORT_RD;
         end
         ST_WALK_HEAD: state_in = ST_WALK_RD;
         ST_WALK_RD: begin
            if (sts.walk_done) state_in = ST_DECIDE;
            else state_in = ST_WALK_LOAD;
         end
         ST_WALK_LOAD: state_in = ST_WALK_EVAL;
         ST_WALK_EVAL: state_in = ST_WALK_RD;
         ST_DECIDE:    state_in = ST_OUT_RD;
         ST_OUT_RD:    state_in = ST_OUT_LOAD;
         ST_OUT_LOAD:  state_in = ST_OUT_SEND;
         ST_OUT_SEND: begin
            if (rsp_take) state_in = sts.out_done ? ST_IDLE : ST_OUT_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      rsp_valid = 1'b0;
      busy      = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            cmd.init_sort = start_emit;
         end
         ST_SORT_RD: begin
            cmd.rd_key    = !sts.sort_done;
            cmd.init_walk = sts.sort_done;
         end
         ST_SORT_STEP: begin
            // j just set (or shifted); fetch order[j-1] or place
            cmd.rd_prev = !sts.j_zero;
            cmd.place   = sts.j_zero;
         end
         ST_SORT_PREV: cmd.ld_prev = 1'b1;
         ST_SORT_CMP: begin
            cmd.shift = sts.less;
            cmd.place = !sts.less;
         end
         ST_WALK_HEAD: cmd.ld_head = 1'b1;
         ST_WALK_RD: begin
            cmd.rd_walk = !sts.walk_done;
         end
         ST_WALK_LOAD: cmd.ld_walk   = 1'b1;
         ST_WALK_EVAL: cmd.eval_walk = 1'b1;
         ST_DECIDE:    cmd.init_out  = 1'b1;
         ST_OUT_RD:    cmd.rd_out    = 1'b1;
         ST_OUT_LOAD:  cmd.ld_out    = 1'b1;
         ST_OUT_SEND: begin
            rsp_valid   = 1'b1;
            cmd.adv_out = rsp_take;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

`ifndef SYNTHESIS
   a_send_only_in_send: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_OUT_SEND)
      else $error("result shown outside send state");
   a_hold_until_taken: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_take) |=> rsp_valid)
      else $error("result dropped before transfer");
   a_start_from_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.init_sort |-> !busy)
      else $error("emit started while busy");
`endif

endmodule

`default_nettype wire

/* design/tsr_datapath.sv */
// ----------------------------------------------------------------------------
// tsr_datapath : pool storage, sort order, chain walk and result data
// Pool stores and the order, trimmed byte and chain tables are memories with
// registered reads; a slot number is fetched in the cycle before its fields.
// ----------------------------------------------------------------------------
`default_nettype none

module tsr_datapath (
   input  wire                 clock,
   input  wire                 reset,
   input  tsr_pkg::dp_cmd_type cmd,
   input  wire                 add_en,
   input  wire                 clear_en,
   input  wire [31:0]          add_seq,
   input  wire [15:0]          add_tlen,
   input  wire [15:0]          add_clen,
   input  wire [6:0]           fallback_min,
   output tsr_pkg::dp_sts_type sts,
   output tsr_pkg::rsp_type    rsp_data
);
   import tsr_pkg::*;

   // pool stores
   logic [31:0] seq_mem  [PoolDepth];
   logic [15:0] tlen_mem [PoolDepth];
   logic [15:0] clen_mem [PoolDepth];
   // run tables
   logic [IdxW-1:0] order_mem [PoolDepth];
   logic [15:0]     bytes_mem [PoolDepth];
   logic [IdxW-1:0] chain_mem [PoolDepth];

   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] i_ff, i_in, j_ff, j_in, kept_ff, kept_in;
   logic [31:0]     key_ff, cur_ff;
   logic            fb_ff, fb_in;

   // registered read ports
   logic [IdxW-1:0] slot_ff;        // fetched order/chain entry
   logic [31:0]     prev_seq_ff;
   logic [IdxW-1:0] w_slot_ff;
   logic [31:0]     w_seq_ff;
   logic [15:0]     w_tlen_ff, w_clen_ff;
   logic [IdxW-1:0] o_slot_ff;
   logic [31:0]     o_seq_ff;
   logic [15:0]     o_bytes_ff;
   logic            o_last_ff;

   logic [IdxW-1:0] ord_addr;       // order table read address
   logic [31:0]     end_seq, diff;
   logic [15:0]     trim;
   logic            keep;

   // pool count and stores
   always_comb begin
      count_in = count_ff;
      if (clear_en) count_in = '0;
      else if (add_en && add_clen != '0 && count_ff < CntW'(PoolDepth))
         count_in = count_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (add_en && add_clen != '0 && count_ff < CntW'(PoolDepth)) begin
         seq_mem[count_ff[IdxW-1:0]]  <= add_seq;
         tlen_mem[count_ff[IdxW-1:0]] <= add_tlen;
         clen_mem[count_ff[IdxW-1:0]] <= add_clen;
      end
   end

   // walk evaluation
   assign end_seq = w_seq_ff + {16'd0, w_tlen_ff};
   assign diff    = end_seq - cur_ff;
   assign keep    = (w_seq_ff != cur_ff) && !diff[31];
   assign trim    = (diff >= {16'd0, w_clen_ff}) ? 16'd0 : (w_clen_ff - diff[15:0]);

   // index and counter updates
   always_comb begin
      i_in    = i_ff;
      j_in    = j_ff;
      kept_in = kept_ff;
      fb_in   = fb_ff;
      if (cmd.init_sort) i_in = '0;
      if (cmd.rd_key) j_in = i_ff;
      if (cmd.shift) j_in = j_ff - 1'b1;
      if (cmd.place) i_in = i_ff + 1'b1;
      if (cmd.init_walk) begin
         i_in    = count_ff - 1'b1;
         kept_in = CntW'(1);
      end
      if (cmd.eval_walk) begin
         i_in = i_ff - 1'b1;
         if (keep) kept_in = kept_ff + 1'b1;
      end
      if (cmd.init_out) begin
         // 5*kept < 4*n, n > min, min != 0
         fb_in = ((({3'd0, kept_ff} << 2) + {3'd0, kept_ff}) < ({3'd0, count_ff} << 2))
                 && ({1'b0, count_ff} > {1'b0, fallback_min}) && (fallback_min != '0);
         i_in  = fb_in ? '0 : kept_ff;
      end
      if (cmd.adv_out) i_in = fb_ff ? i_ff + 1'b1 : i_ff - 1'b1;
   end

   // order table address
   always_comb begin
      ord_addr = j_ff[IdxW-1:0] - 1'b1;
      if (cmd.init_walk || cmd.rd_walk) ord_addr = i_ff[IdxW-1:0] - 1'b1;
      else if (cmd.rd_out) ord_addr = i_ff[IdxW-1:0];
   end

   // tables and registered reads
   always_ff @(posedge clock) begin
      if (cmd.rd_key) begin
         key_ff <= seq_mem[i_ff[IdxW-1:0]];
         bytes_mem[i_ff[IdxW-1:0]] <= clen_mem[i_ff[IdxW-1:0]];
      end
      // slot fetch
      if (cmd.rd_prev || cmd.init_walk || cmd.rd_walk || (cmd.rd_out && fb_ff))
         slot_ff <= order_mem[ord_addr];
      if (cmd.rd_out && !fb_ff) slot_ff <= chain_mem[i_ff[IdxW-1:0] - 1'b1];
      if (cmd.ld_prev) prev_seq_ff <= seq_mem[slot_ff];
      if (cmd.ld_head) begin
         cur_ff       <= seq_mem[slot_ff];
         chain_mem[0] <= slot_ff;
      end
      if (cmd.shift) order_mem[j_ff[IdxW-1:0]] <= slot_ff;
      if (cmd.place) order_mem[j_ff[IdxW-1:0]] <= i_ff[IdxW-1:0];
      if (cmd.ld_walk) begin
         w_slot_ff <= slot_ff;
         w_seq_ff  <= seq_mem[slot_ff];
         w_tlen_ff <= tlen_mem[slot_ff];
         w_clen_ff <= bytes_mem[slot_ff];
      end
      if (cmd.eval_walk && keep) begin
         cur_ff <= w_seq_ff;
         chain_mem[kept_ff[IdxW-1:0]] <= w_slot_ff;
         if (diff != '0) bytes_mem[w_slot_ff] <= trim;
      end
      if (cmd.ld_out) begin
         o_slot_ff  <= slot_ff;
         o_seq_ff   <= seq_mem[slot_ff];
         o_bytes_ff <= bytes_mem[slot_ff];
         o_last_ff  <= fb_ff ? (i_ff + 1'b1 == count_ff) : (i_ff == CntW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         kept_ff  <= '0;
         fb_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         kept_ff  <= kept_in;
         fb_ff    <= fb_in;
      end
   end

   // status
   always_comb begin
      sts.pool_empty = (count_ff == '0);
      sts.sort_done  = (i_ff == count_ff);
      sts.j_zero     = (j_ff == '0);
      sts.less       = key_ff - prev_seq_ff >= 32'h8000_0000;
      sts.walk_done  = (i_ff == '0);
      sts.out_done   = o_last_ff;
   end

   assign rsp_data.slot_index    = 6'(o_slot_ff);
   assign rsp_data.seg_seq       = o_seq_ff;
   assign rsp_data.byte_count    = o_bytes_ff;
   assign rsp_data.fallback_used = fb_ff;
   assign rsp_data.last          = o_last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(PoolDepth))
      else $error("pool count beyond depth");
   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.eval_walk |-> kept_ff <= count_ff)
      else $error("chain longer than pool");
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      clear_en |=> count_ff == '0)
      else $error("clear left entries");
`endif

endmodule

`default_nettype wire

/* design/tcp_segment_reorder_chain.sv */
// ----------------------------------------------------------------------------
// tcp_segment_reorder_chain : top level of the TCP segment reorder chain
// An emit sorts the pool by insertion, walks it to build the chain, decides
// between chain and sorted order, then sends results one at a time, each held
// until taken; the input is stalled for the whole emit. Synchronous reset
// empties the pool and clears the fallback register; stores need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_segment_reorder_chain (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  tsr_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output tsr_pkg::rsp_type  rsp_data,
   input  wire               psel,
   input  wire               penable,
   input  wire               pwrite,
   input  wire [2:0]         paddr,
   input  wire [31:0]        pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import tsr_pkg::*;

   dp_cmd_type dcmd;
   dp_sts_type dsts;
   logic       busy, req_take;
   logic [6:0] fb_min_ff;

   assign req_stall = busy;
   assign req_take  = req_valid && !busy;
   assign pready    = 1'b1;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) fb_min_ff <= '0;
      else if (psel && penable && pwrite && paddr[2] == REG_FALLBACK)
         fb_min_ff <= pwdata[6:0];
   end
   assign prdata = (paddr[2] == REG_FALLBACK) ? {25'd0, fb_min_ff} : 32'd0;

   tsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start_emit (req_take && req_data.cmd == CMD_EMIT),
      .sts        (dsts),
      .rsp_take   (!rsp_stall),
      .cmd        (dcmd),
      .busy       (busy),
      .rsp_valid  (rsp_valid)
   );

   tsr_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (dcmd),
      .add_en       (req_take && req_data.cmd == CMD_ADD),
      .clear_en     (req_take && req_data.cmd == CMD_CLEAR),
      .add_seq      (req_data.seq_number),
      .add_tlen     (req_data.tcp_length),
      .add_clen     (req_data.captured_length),
      .fallback_min (fb_min_ff),
      .sts          (dsts),
      .rsp_data     (rsp_data)
   );

endmodule

`default_nettype wire
